### src/bsa_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared sizes, status and register codes, and the control structs that pass
// between the sequencer and the used-map block.
// ---------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  // Built capacity of the pool.
  localparam int MAX_SLOTS = 256;

  // The used map is scanned one word per cycle.
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W     = $clog2(WORD_W);
  localparam int MAP_W     = NUM_WORDS * WORD_W;
  localparam int MIDX_W    = WSEL_W + POS_W;

  // Width of the effective slot count, min(slot_count, MAX_SLOTS).
  localparam int LIVE_W    = ($clog2(MAX_SLOTS + 1) > 9) ? $clog2(MAX_SLOTS + 1) : 9;

  // Fixed field widths.
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int COUNT_W   = 9;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  // Update request from the sequencer to the used map.
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic [MIDX_W-1:0] idx;
  } map_ctl_t;

  // Result of scanning one map word.
  typedef struct packed {
    logic              found;
    logic [MIDX_W-1:0] idx;
  } scan_res_t;

endpackage

`default_nettype wire

### src/bsa_map.sv
// ---------------------------------------------------------------------------
// Used map
// One bit per slot, cleared by reset. Finds the lowest free live slot in
// the selected word and sets or clears single bits.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_map (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire bsa_pkg::map_ctl_t    ctl,
  input  wire [bsa_pkg::WSEL_W-1:0] scan_word,
  input  wire [bsa_pkg::LIVE_W-1:0] live_n,
  output bsa_pkg::scan_res_t        res
);
  import bsa_pkg::*;

  logic [MAP_W-1:0]  map_r;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] free_vec;
  logic [MIDX_W-1:0] bit_idx;
  logic [POS_W-1:0]  pos;
  logic              found;

  // Bit updates; a slot is marked used on allocate and cleared on free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      if (ctl.set_en) map_r[ctl.idx] <= 1'b1;
      if (ctl.clr_en) map_r[ctl.idx] <= 1'b0;
    end
  end

  // Free and live bits of the selected word.
  always_comb begin
    word = map_r[{scan_word, {POS_W{1'b0}}} +: WORD_W];
    for (int j = 0; j < WORD_W; j++) begin
      bit_idx     = {scan_word, POS_W'(j)};
      free_vec[j] = !word[j] && (LIVE_W'(bit_idx) < live_n);
    end
  end

  // Lowest free bit wins.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        found = 1'b1;
        pos   = POS_W'(j);
      end
    end
  end

  assign res.found = found;
  assign res.idx   = {scan_word, pos};

endmodule

`default_nettype wire

### src/bsa_divider.sv
// ---------------------------------------------------------------------------
// Serial divider
// Restoring division of the address offset by the slot size, one quotient
// bit per cycle. Done pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_divider (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [bsa_pkg::ADDR_W-1:0] dividend,
  input  wire [bsa_pkg::SIZE_W-1:0] divisor,
  output logic                      done,
  output logic [bsa_pkg::ADDR_W-1:0] quotient,
  output logic [bsa_pkg::SIZE_W-1:0] remainder
);
  import bsa_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ADDR_W-1:0] q_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] div_r;

  logic [SIZE_W:0] shifted;
  logic [SIZE_W:0] diff;
  logic            ge;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_r, q_r[ADDR_W-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = (shifted >= {1'b0, div_r});
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ADDR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient shifts in from the right while the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
      q_r   <= {q_r[ADDR_W-2:0], ge};
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### src/bitmap_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// Bitmap slot allocator
// Fixed-size slot pool tracked by a used bitmap. Allocate returns the lowest
// free slot's address; free maps an address back to its slot and releases it.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Carries
//  in_       input      in_valid/in_ready   kind, free_address
//  out_      output     out_valid/out_ready status, slot_address, slot_index
//  cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// Allocate scans the 32-bit map words in order until it finds a free live
// slot, then a multiply and an add form the address. A full pool is reported
// once the last map word has been scanned with no free slot.
// Free runs the offset through the 32-step serial divider; with a zero slot
// size it is rejected without a division.
// One item is in work at a time; in_ready is high only when the sequencer is
// idle. A finished result waits in the output register, so a new item is taken
// while the previous result is still stalled. Reset clears the used map and
// restores the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_kind,
  input  wire  [bsa_pkg::ADDR_W-1:0]      in_free_address,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [bsa_pkg::STATUS_W-1:0]    out_status,
  output logic [bsa_pkg::ADDR_W-1:0]      out_slot_address,
  output logic [bsa_pkg::INDEX_W-1:0]     out_slot_index,
  input  wire                             cfg_we,
  input  wire  [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MUL, S_SUM, S_DSTART, S_DIV, S_CHECK, S_OUT
  } state_t;

  state_t               state_r;
  logic [ADDR_W-1:0]    base_r;
  logic [SIZE_W-1:0]    size_r;
  logic [COUNT_W-1:0]   count_r;
  logic [WSEL_W-1:0]    word_r;
  logic [MIDX_W-1:0]    idx_r;
  logic [MIDX_W+SIZE_W-1:0] prod_r;
  logic [ADDR_W-1:0]    off_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [ADDR_W-1:0]    res_addr_r;
  logic [INDEX_W-1:0]   res_index_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [INDEX_W-1:0]   out_index_r;

  logic [LIVE_W-1:0]    live_n;
  map_ctl_t             map_ctl;
  scan_res_t            scan;
  logic                 div_start;
  logic                 div_done;
  logic [ADDR_W-1:0]    quot;
  logic [SIZE_W-1:0]    rem;
  logic                 free_ok;

  // Effective slot count is capped at the built capacity.
  assign live_n = (LIVE_W'(count_r) > LIVE_W'(MAX_SLOTS)) ? LIVE_W'(MAX_SLOTS)
                                                          : LIVE_W'(count_r);

  // A free is good when the offset divides exactly and lands on a live slot.
  assign free_ok = (rem == '0) && (quot < ADDR_W'(live_n));

  // Map updates: mark the found slot used, or release the freed slot.
  always_comb begin
    map_ctl.set_en = (state_r == S_SCAN) && scan.found;
    map_ctl.clr_en = (state_r == S_CHECK) && free_ok;
    map_ctl.idx    = (state_r == S_SCAN) ? scan.idx : quot[MIDX_W-1:0];
  end

  assign div_start = (state_r == S_DSTART) && (size_r != '0);

  bsa_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (map_ctl),
    .scan_word (word_r),
    .live_n    (live_n),
    .res       (scan)
  );

  bsa_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (off_r),
    .divisor   (size_r),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      size_r      <= SIZE_W'(4);
      count_r     <= COUNT_W'(256);
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE:  base_r  <= cfg_wdata[ADDR_W-1:0];
          CFG_SIZE:  size_r  <= cfg_wdata[SIZE_W-1:0];
          CFG_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
          default:   ;
        endcase
      end

      // The output register empties on a taken result unless a new one loads.
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            word_r <= '0;
            off_r  <= in_free_address - base_r;
            state_r <= (in_kind == KIND_FREE) ? S_DSTART : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan.found) begin
            idx_r   <= scan.idx;
            state_r <= S_MUL;
          end else if (word_r == WSEL_W'(NUM_WORDS - 1)) begin
            res_status_r <= ST_FULL;
            res_addr_r   <= '0;
            res_index_r  <= '0;
            state_r      <= S_OUT;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r  <= {{SIZE_W{1'b0}}, idx_r} * {{MIDX_W{1'b0}}, size_r};
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_status_r <= ST_OK;
          res_addr_r   <= base_r + ADDR_W'(prod_r);
          res_index_r  <= INDEX_W'(idx_r);
          state_r      <= S_OUT;
        end
        S_DSTART: begin
          // A zero slot size has no stride, so every free is a bad address.
          if (size_r == '0) begin
            res_status_r <= ST_BAD;
            res_addr_r   <= '0;
            res_index_r  <= '0;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state_r <= S_CHECK;
        end
        S_CHECK: begin
          res_status_r <= free_ok ? ST_OK : ST_BAD;
          res_addr_r   <= '0;
          res_index_r  <= free_ok ? INDEX_W'(quot) : '0;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_index_r  <= res_index_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_address = out_addr_r;
  assign out_slot_index   = out_index_r;

endmodule

`default_nettype wire

### src/bsa_checker.sv
// ---------------------------------------------------------------------------
// Bitmap slot allocator checker
// Port-level checks on results and on the one-item-at-a-time input side.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [bsa_pkg::STATUS_W-1:0]  out_status,
  input wire [bsa_pkg::ADDR_W-1:0]    out_slot_address,
  input wire [bsa_pkg::INDEX_W-1:0]   out_slot_index
);
  import bsa_pkg::*;

  // Only the three defined status codes ever appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL || out_status == ST_BAD))
    else $error("undefined status code on result");

  // A failed request carries a zero address and a zero index.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_slot_address == '0 && out_slot_index == '0))
    else $error("failed result carries nonzero address or index");

  // The block is busy in the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting an item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_slot_address)
       && $stable(out_slot_index)))
    else $error("stalled result changed");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (.*);

`default_nettype wire

### bench/bitmap_slot_allocator_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Drives allocate and free requests through the valid/ready input channel
// under several pool settings and idling patterns. A shadow copy of the used
// map predicts every result, and each result item is checked field by field.
// ---------------------------------------------------------------------------

module bitmap_slot_allocator_unit_test;
  import bsa_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int QUIET_LIMIT     = 4000;

  // One request item as queued for the sender.
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] free_address;
  } pool_request_t;

  // One predicted result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   slot_address;
    logic [INDEX_W-1:0]  slot_index;
  } slot_result_t;

  // Shadow of the pool: registers, used map and the results still owed.
  class slot_pool_checker;
    logic [ADDR_W-1:0]  base_address;
    logic [SIZE_W-1:0]  slot_size;
    logic [COUNT_W-1:0] slot_count;
    bit                 slot_taken[MAX_SLOTS];
    slot_result_t       pending_results[$];
    int                 mismatches;

    function new();
      base_address = '0;
      slot_size    = SIZE_W'(4);
      slot_count   = COUNT_W'(256);
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      mismatches   = 0;
    endfunction

    // Slots actually in play: the count is capped at the built capacity.
    function int live_count();
      return (int'(slot_count) < MAX_SLOTS) ? int'(slot_count) : MAX_SLOTS;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_BASE:  base_address = value[ADDR_W-1:0];
        CFG_SIZE:  slot_size    = value[SIZE_W-1:0];
        CFG_COUNT: slot_count   = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of an accepted request and update the used map.
    function void note_request(logic kind, logic [ADDR_W-1:0] free_address);
      slot_result_t      res;
      int                live;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] index;
      res  = '0;
      live = live_count();
      if (kind == KIND_ALLOC) begin
        res.status = ST_FULL;
        for (int i = 0; i < live; i++) begin
          if (!slot_taken[i]) begin
            slot_taken[i]    = 1'b1;
            res.status       = ST_OK;
            res.slot_address = base_address + ADDR_W'(i) * ADDR_W'(slot_size);
            res.slot_index   = INDEX_W'(i);
            break;
          end
        end
      end else begin
        // The offset wraps, so an address below the base lands out of range.
        offset = free_address - base_address;
        if (slot_size == 0 || (offset % ADDR_W'(slot_size)) != 0) begin
          res.status = ST_BAD;
        end else begin
          index = offset / ADDR_W'(slot_size);
          if (index >= ADDR_W'(live)) begin
            res.status = ST_BAD;
          end else begin
            slot_taken[index] = 1'b0;
            res.slot_index    = index[INDEX_W-1:0];
          end
        end
      end
      pending_results.push_back(res);
    endfunction

    // Compare a result item with the oldest prediction.
    function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] slot_address,
                               logic [INDEX_W-1:0] slot_index);
      slot_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending: status %0d address 0x%08h index %0d",
                 $time, status, slot_address, slot_index);
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, status);
      end
      if (slot_address !== want.slot_address) begin
        mismatches++;
        $display("%0t: slot_address mismatch: expected 0x%08h, actual 0x%08h",
                 $time, want.slot_address, slot_address);
      end
      if (slot_index !== want.slot_index) begin
        mismatches++;
        $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                 $time, want.slot_index, slot_index);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = 1'b0;
  logic [ADDR_W-1:0]     in_free_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ADDR_W-1:0]     out_slot_address;
  logic [INDEX_W-1:0]    out_slot_index;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  slot_pool_checker pool = new();
  pool_request_t    request_q[$];
  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;
  logic             hold_start = 1'b0;

  bitmap_slot_allocator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_address (out_slot_address),
    .out_slot_index   (out_slot_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sender: presents queued items, idling at random between them.
  initial begin : sender
    pool_request_t req;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (in_valid && in_ready) begin
        pool.note_request(in_kind, in_free_address);
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req = request_q.pop_front();
          in_valid        <= 1'b1;
          in_kind         <= req.kind;
          in_free_address <= req.free_address;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks results and stalls at random, or for a long hold-off.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        pool.check_result(out_status, out_slot_address, out_slot_index);
      end
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no item moving.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function void queue_request(logic kind, logic [ADDR_W-1:0] free_address);
    pool_request_t req;
    req.kind         = kind;
    req.free_address = free_address;
    request_q.push_back(req);
  endfunction

  // Mostly well-formed traffic: allocates and frees of real slot addresses,
  // with some unaligned, out-of-range and arbitrary addresses mixed in.
  function void queue_random_request();
    int                pick;
    int                live;
    int                idx;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    live = pool.live_count();
    if (pick < 50) begin
      queue_request(KIND_ALLOC, $urandom());
    end else begin
      if (live == 0) begin
        idx = $urandom_range(3);
      end else if ($urandom_range(9) == 0) begin
        idx = live + $urandom_range(2);
      end else begin
        idx = $urandom_range(live - 1);
      end
      addr = pool.base_address + ADDR_W'(idx) * ADDR_W'(pool.slot_size);
      if (pick >= 93) begin
        addr = $urandom();
      end else if (pick >= 86 && pool.slot_size > 1) begin
        addr = addr + ADDR_W'($urandom_range(int'(pool.slot_size) - 1, 1));
      end
      queue_request(KIND_FREE, addr);
    end
  endfunction

  // Register write; the enable drops between writes so writes never merge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool.write_reg(index, value);
    @(posedge clk);
  endtask

  task automatic apply_config(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
                              logic [COUNT_W-1:0] count);
    write_reg(CFG_BASE, CFG_DATA_W'(base));
    write_reg(CFG_SIZE, CFG_DATA_W'(size));
    write_reg(CFG_COUNT, CFG_DATA_W'(count));
  endtask

  // Wait until every queued item is accepted and every result has arrived.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || pool.pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence: directed cases, then random phases.
  initial begin : main_sequence
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one allocate, its free, and a far address.
    queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_FREE, 32'h0000_0000);
    queue_request(KIND_FREE, 32'hFFFF_FFFF);
    wait_idle();

    // Count above capacity with the widest stride: last slot and one past it.
    apply_config(32'h1234_5678, 16'hFFFF, 9'd511);
    queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_FREE, 32'h1234_5678 + 32'd255 * 32'h0000_FFFF);
    queue_request(KIND_FREE, 32'h1234_5678 + 32'd256 * 32'h0000_FFFF);
    wait_idle();

    // Zero slot size: allocates share the base, every free is rejected.
    write_reg(CFG_SIZE, '0);
    write_reg(CFG_COUNT, CFG_DATA_W'(2));
    queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_FREE, 32'h1234_5678);
    wait_idle();

    // Zero slot count: nothing to allocate and nothing to free.
    write_reg(CFG_COUNT, '0);
    queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_FREE, 32'h1234_5678);
    wait_idle();

    // Small pool near the top of memory: wrapped addresses, a full pool,
    // unaligned, out-of-range and below-base frees, and a double free.
    apply_config(32'hFFFF_FFF0, 16'd16, 9'd3);
    queue_request(KIND_FREE, 32'hFFFF_FFF0);
    queue_request(KIND_FREE, 32'h0000_0000);
    repeat (4) queue_request(KIND_ALLOC, $urandom());
    queue_request(KIND_FREE, 32'h0000_0008);
    queue_request(KIND_FREE, 32'h0000_0020);
    queue_request(KIND_FREE, 32'hFFFF_FFE0);
    queue_request(KIND_FREE, 32'h0000_0000);
    queue_request(KIND_FREE, 32'h0000_0000);
    wait_idle();

    // Random phases, each with its own settings and idling pattern.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_config($urandom(), 16'd1, 9'd256);
        1: apply_config(32'hFFFF_FFFF, 16'hFFFF, 9'd1);
        2: apply_config($urandom(), SIZE_W'($urandom_range(64, 1)),
                        COUNT_W'($urandom_range(20, 2)));
        3: apply_config(32'h0000_0000, 16'd0, COUNT_W'($urandom_range(8, 1)));
        4: apply_config($urandom(), SIZE_W'($urandom()), 9'd511);
        5: apply_config($urandom(), SIZE_W'($urandom_range(64, 1)),
                        COUNT_W'($urandom_range(40, 2)));
        6: apply_config($urandom(), SIZE_W'($urandom_range(8, 1)), 9'd0);
        default: apply_config($urandom(), SIZE_W'($urandom_range(300, 1)),
                              COUNT_W'($urandom_range(256, 1)));
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 66;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 66;
        end
        default: begin
          sender_idle_pct    = 37;
          receiver_stall_pct = 37;
        end
      endcase
      // The first phase starts with the receiver held off while items pile up.
      if (phase == 0) begin
        hold_start <= 1'b1;
      end
      repeat (ITEMS_PER_PHASE) queue_random_request();
      wait_idle();
    end

    if (pool.mismatches == 0 && pool.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
